// File: design/pat_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, codes and widths for the positional array table.
package pat_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned WordW        = 32;
  localparam int unsigned PosW         = 4;
  localparam int unsigned KindW        = 3;

  // Operation codes carried in the input tuser field.
  localparam logic [KindW-1:0] KindInsert  = 3'd0;
  localparam logic [KindW-1:0] KindDelete  = 3'd1;
  localparam logic [KindW-1:0] KindReverse = 3'd2;
  localparam logic [KindW-1:0] KindSearch  = 3'd3;
  localparam logic [KindW-1:0] KindDisplay = 3'd4;

  // Per-cycle command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_MIRROR = 3'd3,
    CMD_ROTATE = 3'd4
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic [PosW-1:0]   pos;
    logic [WordW-1:0]  value;
  } cell_ctrl_t;

endpackage

// File: design/pat_cell.sv
`timescale 1ns / 1ps
// One storage cell of the array chain: holds a single entry.
module pat_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pat_pkg::cell_ctrl_t         ctrl_i,
  input  logic [pat_pkg::WordW-1:0]   left_i,
  input  logic [pat_pkg::WordW-1:0]   right_i,
  input  logic [pat_pkg::WordW-1:0]   mirror_i,
  output logic [pat_pkg::WordW-1:0]   entry_o
);

  // 1-based slot number of this cell, wide enough for depths up to 255
  localparam logic [7:0] SlotNum = 8'(Idx + 1);

  logic [pat_pkg::WordW-1:0] entry_d, entry_q;
  logic [7:0]                pos_ext;

  assign pos_ext = 8'(ctrl_i.pos);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      pat_pkg::CMD_INSERT: begin
        if (SlotNum == pos_ext) begin
          entry_d = ctrl_i.value;
        end else if (SlotNum > pos_ext) begin
          entry_d = left_i;
        end
      end
      pat_pkg::CMD_DELETE: begin
        if (SlotNum >= pos_ext) begin
          entry_d = right_i;
        end
      end
      pat_pkg::CMD_MIRROR: entry_d = mirror_i;
      pat_pkg::CMD_ROTATE: entry_d = right_i;
      default:             entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: design/positional_array_table_unit.sv
`timescale 1ns / 1ps
// Top level: positional array table built as a chain of entry cells.
//
// Keeps DEPTH signed 32-bit entries, all zero after reset (rst_ni, async).
// Input stream: tuser = kind (insert, delete, reverse, search, display),
// tdata = position and value. Output stream: tdata = data and slot,
// tuser = found and bad_position flags, tlast = final result of an item.
// Insert, delete, reverse and unused kinds act on all cells at once;
// their single result is registered in the cycle after the transaction,
// and a new item can follow every cycle while the receiver keeps up.
// Search rotates the chain once around, comparing the head cell with the
// key; the result is registered together with the final rotation.
// Display rotates the chain one step per delivered result, giving DEPTH
// results; the chain ends back in its original order.
// Both scans read the entries only through the single head cell.
// One output register parts the two sides: while it holds an untaken
// result and m_axis_tready is low, the chain stalls and s_axis_tready drops.
// A position outside 1..DEPTH on insert or delete is reported with
// bad_position set and leaves the array untouched.
module positional_array_table_unit #(
  parameter int unsigned DEPTH = pat_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [3:0] position, [35:4] value, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data_out, [35:32] slot_out, rest zero
  output logic [1:0]  m_axis_tuser,   // [0] found, [1] bad_position
  output logic        m_axis_tlast
);

  localparam int unsigned CntW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SlotW = CntW + 1;
  localparam logic [CntW-1:0] CntLast = CntW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SHOW = 3'b100
  } state_e;

  state_e state_d, state_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  // search bookkeeping
  logic [pat_pkg::WordW-1:0] key_d, key_q;
  logic                      hit_d, hit_q;
  logic [pat_pkg::PosW-1:0]  hit_slot_d, hit_slot_q;

  // output register
  logic                      out_valid_q;
  logic                      out_load;
  logic [pat_pkg::WordW-1:0] out_data_d, out_data_q;
  logic [pat_pkg::PosW-1:0]  out_slot_d, out_slot_q;
  logic                      out_found_d, out_found_q;
  logic                      out_bad_d, out_bad_q;
  logic                      out_last_d, out_last_q;
  logic                      out_free;

  // input fields
  logic [pat_pkg::KindW-1:0] in_kind;
  logic [pat_pkg::PosW-1:0]  in_pos;
  logic [pat_pkg::WordW-1:0] in_value;
  logic                      in_take;
  logic                      pos_ok;

  logic [SlotW-1:0]          slot_full;
  logic [pat_pkg::PosW-1:0]  slot_now;
  logic                      head_match;

  pat_pkg::cell_ctrl_t       ctrl;
  logic [pat_pkg::WordW-1:0] entry [DEPTH];

  assign in_kind  = s_axis_tuser;
  assign in_pos   = s_axis_tdata[3:0];
  assign in_value = s_axis_tdata[35:4];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign pos_ok = (in_pos != '0) && (32'(in_pos) <= 32'(DEPTH));

  // slot of the entry currently at the head cell during a scan
  assign slot_full  = SlotW'(cnt_q) + SlotW'(1);
  assign slot_now   = pat_pkg::PosW'(slot_full);
  assign head_match = (entry[0] == key_q);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    ctrl.cmd    = pat_pkg::CMD_HOLD;
    ctrl.pos    = in_pos;
    ctrl.value  = in_value;
    out_load    = 1'b0;
    out_data_d  = '0;
    out_slot_d  = '0;
    out_found_d = 1'b0;
    out_bad_d   = 1'b0;
    out_last_d  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_kind)
            pat_pkg::KindInsert, pat_pkg::KindDelete: begin
              out_load = 1'b1;
              if (pos_ok) begin
                ctrl.cmd   = (in_kind == pat_pkg::KindInsert) ? pat_pkg::CMD_INSERT
                                                             : pat_pkg::CMD_DELETE;
                out_slot_d = in_pos;
              end else begin
                out_bad_d = 1'b1;
              end
            end
            pat_pkg::KindReverse: begin
              ctrl.cmd = pat_pkg::CMD_MIRROR;
              out_load = 1'b1;
            end
            pat_pkg::KindSearch: begin
              state_d    = ST_SCAN;
              key_d      = in_value;
              hit_d      = 1'b0;
              hit_slot_d = '0;
            end
            pat_pkg::KindDisplay: begin
              state_d = ST_SHOW;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cnt_q != CntLast) begin
          ctrl.cmd = pat_pkg::CMD_ROTATE;
          cnt_d    = cnt_q + CntW'(1);
          if (!hit_q && head_match) begin
            hit_d      = 1'b1;
            hit_slot_d = slot_now;
          end
        end else if (out_free) begin
          // final rotation restores the original order
          ctrl.cmd    = pat_pkg::CMD_ROTATE;
          out_load    = 1'b1;
          out_data_d  = key_q;
          out_found_d = hit_q || head_match;
          out_slot_d  = hit_q ? hit_slot_q : (head_match ? slot_now : '0);
          state_d     = ST_IDLE;
          cnt_d       = '0;
        end
      end

      ST_SHOW: begin
        if (out_free) begin
          ctrl.cmd   = pat_pkg::CMD_ROTATE;
          out_load   = 1'b1;
          out_data_d = entry[0];
          out_slot_d = slot_now;
          out_last_d = (cnt_q == CntLast);
          if (cnt_q == CntLast) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    hit_slot_q <= hit_slot_d;
    if (out_load) begin
      out_data_q  <= out_data_d;
      out_slot_q  <= out_slot_d;
      out_found_q <= out_found_d;
      out_bad_q   <= out_bad_d;
      out_last_q  <= out_last_d;
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: left feeds insert, right feeds delete and rotate
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [pat_pkg::WordW-1:0] left_w, right_w;

    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // rotate wraps the head around; delete zero-fills the end
      assign right_w = (ctrl.cmd == pat_pkg::CMD_ROTATE) ? entry[0] : '0;
    end else begin : g_link
      assign right_w = entry[i+1];
    end

    pat_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .mirror_i(entry[DEPTH-1-i]),
      .entry_o (entry[i])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_slot_q, out_data_q};
  assign m_axis_tuser  = {out_bad_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_idle_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("scan counter not cleared in idle");

  a_display_enters_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (in_kind == pat_pkg::KindDisplay)) |=> (state_q == ST_SHOW))
    else $error("display transaction did not start the show sequence");

  a_show_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SHOW) && out_free && (cnt_q == CntLast))
      |=> (m_axis_tvalid && m_axis_tlast && (state_q == ST_IDLE)))
    else $error("final display result not marked last");

endmodule
